### rtl/dhos_pkg.sv
// Package for the diagonal hit overlap suppressor.
// Holds table sizing, field widths and the controller/datapath handshake structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dhos_pkg;

  localparam int MAX_KEPT = 64;
  localparam int IDX_W    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CNT_W    = $clog2(MAX_KEPT + 1);

  localparam int POS_W    = 32;
  localparam int LEN_W    = 16;
  localparam int END_W    = POS_W + 1;
  localparam int ENTRY_W  = 2 * POS_W + LEN_W;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

### rtl/dhos_if.sv
// Request channels of the diagonal hit overlap suppressor.
// Depends on dhos_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dhos_in_if import dhos_pkg::*;;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] x_start;
  logic [POS_W-1:0] y_start;
  logic [LEN_W-1:0] run_length;
  logic             enabled;
  logic             batch_end;

  modport source (output valid, x_start, y_start, run_length, enabled, batch_end,
                  input ready);
  modport sink   (input valid, x_start, y_start, run_length, enabled, batch_end,
                  output ready);
endinterface

interface dhos_out_if;
  logic valid;
  logic ready;
  logic keep;
  logic table_full;

  modport source (output valid, keep, table_full, input ready);
  modport sink   (input valid, keep, table_full, output ready);
endinterface

`default_nettype wire

### rtl/dhos_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dhos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/dhos_ctrl.sv
// Controller of the overlap suppressor: accept, scan the kept table, commit.
// Depends on dhos_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module dhos_ctrl import dhos_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire dp_sts_t   sts,
  output ctrl_cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == ST_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule

`default_nettype wire

### rtl/dhos_dp.sv
// Datapath of the overlap suppressor: request registers, kept-hit table,
// range comparator, fill count and output register.
// Depends on dhos_pkg and dhos_ram.
`timescale 1ns / 1ps
`default_nettype none

module dhos_dp import dhos_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ctrl_cmd_t        cmd,
  output dp_sts_t               sts,
  input  wire logic [POS_W-1:0] x_start,
  input  wire logic [POS_W-1:0] y_start,
  input  wire logic [LEN_W-1:0] run_length,
  input  wire logic             enabled,
  input  wire logic             batch_end,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  keep,
  output logic                  table_full
);

  logic [POS_W-1:0] x0_r, y0_r;
  logic [END_W-1:0] x1_r, y1_r;
  logic [LEN_W-1:0] len_r;
  logic             on_r, last_r;
  logic [CNT_W-1:0] idx_r, cnt_r;
  logic             pend_r, hit_r;
  logic             out_vld_r, keep_r, full_r;

  logic             issue, match, keep_c, full_c, we;
  logic [ENTRY_W-1:0] rdata;
  logic [POS_W-1:0] sx, sy;
  logic [LEN_W-1:0] sl;
  logic [END_W-1:0] sx1, sy1;

  dhos_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_KEPT)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata ({x0_r, y0_r, len_r}),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (rdata)
  );

  // one stored entry against the held request: closed ranges meet on both axes
  always_comb begin
    {sx, sy, sl} = rdata;
    sx1   = {1'b0, sx} + {{(END_W-LEN_W){1'b0}}, sl};
    sy1   = {1'b0, sy} + {{(END_W-LEN_W){1'b0}}, sl};
    match = ({1'b0, x0_r} <= sx1) && ({1'b0, sx} <= x1_r) &&
            ({1'b0, y0_r} <= sy1) && ({1'b0, sy} <= y1_r);
  end

  assign issue  = cmd.scan && on_r && !hit_r && (idx_r < cnt_r);
  assign keep_c = on_r && !hit_r;
  assign full_c = keep_c && (cnt_r == CNT_W'(MAX_KEPT));
  assign we     = cmd.commit && keep_c && !full_c;

  assign sts.scan_done = !pend_r && (!on_r || hit_r || (idx_r == cnt_r));
  assign sts.out_free  = !out_vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0_r   <= x_start;
      y0_r   <= y_start;
      x1_r   <= {1'b0, x_start} + {{(END_W-LEN_W){1'b0}}, run_length};
      y1_r   <= {1'b0, y_start} + {{(END_W-LEN_W){1'b0}}, run_length};
      len_r  <= run_length;
      on_r   <= enabled;
      last_r <= batch_end;
    end
    if (cmd.commit) begin
      keep_r <= keep_c;
      full_r <= full_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      cnt_r     <= '0;
      pend_r    <= 1'b0;
      hit_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx_r  <= '0;
        pend_r <= 1'b0;
        hit_r  <= 1'b0;
      end else begin
        pend_r <= issue;
        if (issue) begin
          idx_r <= idx_r + CNT_W'(1);
        end
        if (pend_r && match) begin
          hit_r <= 1'b1;
        end
      end
      if (cmd.commit) begin
        priority if (last_r) begin
          cnt_r <= '0;
        end else if (we) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      if (cmd.commit) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_vld_r;
  assign keep       = keep_r;
  assign table_full = full_r;

endmodule

`default_nettype wire

### rtl/diagonal_hit_overlap_suppressor.sv
// Greedy overlap suppression of diagonal alignment hits.
//
// in_ch carries one hit per request: x_start, y_start, run_length, enabled
// and batch_end. out_ch returns one result per hit: keep and table_full.
// A hit is kept when enabled and no hit stored earlier in the batch overlaps
// it on both axes; kept hits are stored in a 64-entry table until the table
// is full, after which they are still reported with table_full set.
// The table empties after the hit that carries batch_end.
// A hit is compared with the stored entries one per cycle through the table's
// single read port; an overlap found early ends the scan before every stored
// entry is read. A disabled hit, or any hit against an empty table, needs no
// comparison. One hit is worked on at a time; the next is accepted as soon
// as the current one leaves the scan for the output register.
// Reset (rst_n low, synchronous) empties the table and drops any pending
// result. A stalled receiver holds the result in the output register; the
// block accepts one more hit and parks its result until the register frees.
// Depends on dhos_pkg, dhos_if, dhos_ctrl and dhos_dp.
`timescale 1ns / 1ps
`default_nettype none

module diagonal_hit_overlap_suppressor import dhos_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dhos_in_if.sink    in_ch,
  dhos_out_if.source out_ch
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  logic      in_ready;

  dhos_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dhos_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .x_start    (in_ch.x_start),
    .y_start    (in_ch.y_start),
    .run_length (in_ch.run_length),
    .enabled    (in_ch.enabled),
    .batch_end  (in_ch.batch_end),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .keep       (out_ch.keep),
    .table_full (out_ch.table_full)
  );

  assign in_ch.ready = in_ready;

endmodule

`default_nettype wire

### rtl/dhos_checker.sv
// Port-level checks for the overlap suppressor, bound to the top level.
// Depends on nothing but the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module dhos_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic keep,
  input wire logic table_full
);

  logic       in_acc, out_acc;
  logic [1:0] open_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // requests accepted but not yet answered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
    end else begin
      open_r <= open_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(keep) && $stable(table_full))
    else $error("result changed while stalled");

  a_full_needs_keep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> keep || !table_full)
    else $error("table_full set on a dropped hit");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> open_r != 2'd0)
    else $error("result with no open request");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    open_r == 2'd2 |-> !in_ready)
    else $error("request accepted with two already open");

endmodule

bind diagonal_hit_overlap_suppressor dhos_checker u_dhos_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .keep       (out_ch.keep),
  .table_full (out_ch.table_full)
);

`default_nettype wire
